// ===== rtl/wpm_pkg.sv =====
// ----------------------------------------------------------------------------
// wpm_pkg
// Shared types and constants for the WAV byte stream to mono converter.
// ----------------------------------------------------------------------------
package wpm_pkg;

  // Result kinds
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  // Header status codes
  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_NOT_WAVE     = 3'd1;
  localparam logic [2:0] ST_NOT_PCM      = 3'd2;
  localparam logic [2:0] ST_BAD_CHANNELS = 3'd3;
  localparam logic [2:0] ST_BAD_WIDTH    = 3'd4;

  // Bytes per sample
  localparam logic [2:0] SW_8BIT  = 3'd1;
  localparam logic [2:0] SW_16BIT = 3'd2;
  localparam logic [2:0] SW_24BIT = 3'd3;
  localparam logic [2:0] SW_32BIT = 3'd4;

  // Header layout
  localparam int unsigned   HEADER_BYTES = 44;
  localparam logic [15:0]   FORMAT_PCM   = 16'd1;
  // "RIFF", first byte in the low lane
  localparam logic [31:0]   RIFF_TAG     = 32'h4646_4952;

  // Position of a sample within its frame
  typedef enum logic [1:0] {
    TAG_MONO  = 2'd0,
    TAG_LEFT  = 2'd1,
    TAG_RIGHT = 2'd2
  } tag_t;

  // Work item from the parser to the sample unit
  typedef struct packed {
    logic        kind;
    logic [2:0]  status;
    logic [31:0] rate;
    logic [1:0]  chan;
    logic [2:0]  rep_width;
    logic [31:0] raw;
    logic [2:0]  samp_width;
    tag_t        tag;
  } mid_item_t;

  // Finished result
  typedef struct packed {
    logic        kind;
    logic [2:0]  status;
    logic [16:0] mono;
    logic [31:0] rate;
    logic [1:0]  chan;
    logic [2:0]  width;
  } out_item_t;

endpackage

// ===== rtl/wpm_fifo.sv =====
// ----------------------------------------------------------------------------
// wpm_fifo
// Small register queue with registered head, full/empty flags and fill count.
// ----------------------------------------------------------------------------
module wpm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           push_data,
  input  logic                       pop,
  output logic [WIDTH-1:0]           pop_data,
  output logic                       empty,
  output logic                       full,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    cnt_r;
  logic             do_push, do_pop;

  assign empty    = (cnt_r == '0);
  assign full     = (cnt_r == FULL_CNT);
  assign count    = cnt_r;
  assign pop_data = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  // Hold pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + AW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (!do_push && do_pop) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL_CNT)
    else $error("queue fill count beyond depth");

endmodule

// ===== rtl/wpm_front.sv =====
// ----------------------------------------------------------------------------
// wpm_front
// Header parser and sample byte assembler; emits one work item per report or
// completed sample.
// ----------------------------------------------------------------------------
module wpm_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic [7:0]         data_byte,
  input  logic               end_of_file,
  output logic               item_push,
  output wpm_pkg::mid_item_t item
);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_DATA,
    PH_SKIP
  } phase_t;

  localparam logic [5:0] LAST_POS = 6'(wpm_pkg::HEADER_BYTES - 1);

  phase_t      phase_r, phase_nxt;
  logic [5:0]  pos_r, pos_nxt;
  logic        riff_r, riff_nxt;
  logic [15:0] fmt_r, fmt_nxt;
  logic [15:0] chan_r, chan_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [15:0] bits_r, bits_nxt;
  logic [23:0] part_r, part_nxt;
  logic [1:0]  gath_r, gath_nxt;
  logic        rpend_r, rpend_nxt;
  logic [2:0]  st;
  logic [2:0]  width;
  logic [31:0] raw;

  // Header verdict from the captured words
  always_comb begin
    if (!riff_r) begin
      st = wpm_pkg::ST_NOT_WAVE;
    end else if (fmt_r != wpm_pkg::FORMAT_PCM) begin
      st = wpm_pkg::ST_NOT_PCM;
    end else if (chan_r == 16'd0 || chan_r > 16'd2) begin
      st = wpm_pkg::ST_BAD_CHANNELS;
    end else if (!(bits_r inside {16'd8, 16'd16, 16'd24, 16'd32})) begin
      st = wpm_pkg::ST_BAD_WIDTH;
    end else begin
      st = wpm_pkg::ST_OK;
    end
  end

  assign width = bits_r[5:3];
  assign raw   = {8'd0, part_r} | ({24'd0, data_byte} << {gath_r, 3'b000});

  // Classify the byte and advance the parse
  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    riff_nxt  = riff_r;
    fmt_nxt   = fmt_r;
    chan_nxt  = chan_r;
    rate_nxt  = rate_r;
    bits_nxt  = bits_r;
    part_nxt  = part_r;
    gath_nxt  = gath_r;
    rpend_nxt = rpend_r;
    item_push = 1'b0;
    item      = '0;
    if (accept) begin
      unique case (phase_r)
        PH_HEADER: begin
          if (pos_r < 6'd4 && data_byte != wpm_pkg::RIFF_TAG[{pos_r[1:0], 3'b000} +: 8]) begin
            riff_nxt = 1'b0;
          end
          if (pos_r == 6'd20) fmt_nxt[7:0]   = data_byte;
          if (pos_r == 6'd21) fmt_nxt[15:8]  = data_byte;
          if (pos_r == 6'd22) chan_nxt[7:0]  = data_byte;
          if (pos_r == 6'd23) chan_nxt[15:8] = data_byte;
          if (pos_r >= 6'd24 && pos_r <= 6'd27) begin
            rate_nxt[{pos_r[1:0], 3'b000} +: 8] = data_byte;
          end
          if (pos_r == 6'd34) bits_nxt[7:0]  = data_byte;
          if (pos_r == 6'd35) bits_nxt[15:8] = data_byte;
          if (pos_r >= LAST_POS || end_of_file) begin
            item_push   = 1'b1;
            item.kind   = wpm_pkg::KIND_REPORT;
            item.status = (pos_r >= LAST_POS) ? st : wpm_pkg::ST_NOT_WAVE;
            item.rate   = rate_nxt;
            if (pos_r >= LAST_POS && st == wpm_pkg::ST_OK) begin
              item.chan      = chan_r[1:0];
              item.rep_width = width;
              phase_nxt      = PH_DATA;
            end else begin
              phase_nxt      = PH_SKIP;
            end
          end else begin
            pos_nxt = pos_r + 6'd1;
          end
        end
        PH_DATA: begin
          if (({1'b0, gath_r} + 3'd1) >= width) begin
            item_push       = 1'b1;
            item.kind       = wpm_pkg::KIND_SAMPLE;
            item.raw        = raw;
            item.samp_width = width;
            part_nxt        = '0;
            gath_nxt        = '0;
            if (chan_r == 16'd1) begin
              item.tag = wpm_pkg::TAG_MONO;
            end else if (!rpend_r) begin
              item.tag  = wpm_pkg::TAG_LEFT;
              rpend_nxt = 1'b1;
            end else begin
              item.tag  = wpm_pkg::TAG_RIGHT;
              rpend_nxt = 1'b0;
            end
          end else begin
            part_nxt = raw[23:0];
            gath_nxt = gath_r + 2'd1;
          end
        end
        default: begin
          // drop bytes after a header error
        end
      endcase
      // Restart for the next file
      if (end_of_file) begin
        phase_nxt = PH_HEADER;
        pos_nxt   = '0;
        riff_nxt  = 1'b1;
        fmt_nxt   = '0;
        chan_nxt  = '0;
        rate_nxt  = '0;
        bits_nxt  = '0;
        part_nxt  = '0;
        gath_nxt  = '0;
        rpend_nxt = 1'b0;
      end
    end
  end

  // Hold parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      pos_r   <= '0;
      riff_r  <= 1'b1;
      fmt_r   <= '0;
      chan_r  <= '0;
      rate_r  <= '0;
      bits_r  <= '0;
      part_r  <= '0;
      gath_r  <= '0;
      rpend_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      riff_r  <= riff_nxt;
      fmt_r   <= fmt_nxt;
      chan_r  <= chan_nxt;
      rate_r  <= rate_nxt;
      bits_r  <= bits_nxt;
      part_r  <= part_nxt;
      gath_r  <= gath_nxt;
      rpend_r <= rpend_nxt;
    end
  end

  a_skip_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_SKIP) |-> !item_push)
    else $error("work item issued after a header error");

endmodule

// ===== rtl/wpm_back.sv =====
// ----------------------------------------------------------------------------
// wpm_back
// Sample unit: scales assembled samples to 16 bits, folds stereo pairs and
// writes finished results to the output queue.
// ----------------------------------------------------------------------------
module wpm_back #(
  parameter int OUT_DEPTH = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           mid_empty,
  input  wpm_pkg::mid_item_t             mid_item,
  output logic                           mid_pop,
  input  logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
  output logic                           out_wr,
  output wpm_pkg::out_item_t             out_item
);

  localparam int CW = $clog2(OUT_DEPTH+1);
  localparam logic [CW:0] DEPTH_LIM = (CW+1)'(OUT_DEPTH);

  // stage A
  logic        va_r;
  logic        a_kind_r;
  logic [2:0]  a_status_r;
  logic [31:0] a_rate_r;
  logic [1:0]  a_chan_r;
  logic [2:0]  a_width_r;
  logic [2:0]  a_sw_r;
  wpm_pkg::tag_t a_tag_r;
  logic [15:0] a_direct_r;
  logic [31:0] a_mag_r;
  logic        a_neg_r;
  // stage B
  logic        vb_r;
  logic        b_kind_r;
  logic [2:0]  b_status_r;
  logic [31:0] b_rate_r;
  logic [1:0]  b_chan_r;
  logic [2:0]  b_width_r;
  wpm_pkg::tag_t b_tag_r;
  logic [15:0] b_s_r;
  logic [15:0] held_r;

  logic [CW:0]  inflight;
  logic [31:0]  pattern;
  logic [15:0]  direct;
  logic [15:0]  q0;
  logic [32:0]  prod;
  logic [15:0]  q4;
  logic [15:0]  q;
  logic [15:0]  s;

  // Issue only when the output queue has room for everything in flight
  assign inflight = {1'b0, out_count} + {{CW{1'b0}}, va_r} + {{CW{1'b0}}, vb_r};
  assign mid_pop  = !mid_empty && (inflight < DEPTH_LIM);

  // Stage A: sign-extend and take magnitude; widen 8-bit samples to 16 bits
  always_comb begin
    pattern = (mid_item.samp_width == wpm_pkg::SW_24BIT) ?
              {{8{mid_item.raw[23]}}, mid_item.raw[23:0]} : mid_item.raw;
    if (mid_item.samp_width == wpm_pkg::SW_8BIT) begin
      direct = {mid_item.raw[7], mid_item.raw[7:0], 7'd0};
    end else begin
      direct = mid_item.raw[15:0];
    end
  end

  // Stage B: divide by 256 or 65538, truncating toward zero
  always_comb begin
    q0   = a_mag_r[31:16];
    prod = {1'b0, q0, 16'd0} + {16'd0, q0, 1'b0};
    q4   = (prod > {1'b0, a_mag_r}) ? q0 - 16'd1 : q0;
    q    = (a_sw_r == wpm_pkg::SW_24BIT) ? a_mag_r[23:8] : q4;
    case (a_sw_r) inside
      wpm_pkg::SW_8BIT, wpm_pkg::SW_16BIT: s = a_direct_r;
      default:                             s = a_neg_r ? (16'd0 - q) : q;
    endcase
  end

  // Fold frames into the result
  always_comb begin
    out_item        = '0;
    out_item.kind   = b_kind_r;
    out_item.status = b_status_r;
    out_item.rate   = b_rate_r;
    out_item.chan   = b_chan_r;
    out_item.width  = b_width_r;
    out_wr          = 1'b0;
    if (vb_r) begin
      if (b_kind_r == wpm_pkg::KIND_REPORT) begin
        out_wr = 1'b1;
      end else begin
        case (b_tag_r)
          wpm_pkg::TAG_MONO: begin
            out_wr        = 1'b1;
            out_item.mono = {b_s_r, 1'b0};
          end
          wpm_pkg::TAG_RIGHT: begin
            out_wr        = 1'b1;
            out_item.mono = {held_r[15], held_r} + {b_s_r[15], b_s_r};
          end
          default: out_wr = 1'b0;
        endcase
      end
    end
  end

  // Advance stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      va_r <= mid_pop;
      vb_r <= va_r;
    end
  end

  // Advance stage payloads and hold the left sample
  always_ff @(posedge clk) begin
    a_kind_r   <= mid_item.kind;
    a_status_r <= mid_item.status;
    a_rate_r   <= mid_item.rate;
    a_chan_r   <= mid_item.chan;
    a_width_r  <= mid_item.rep_width;
    a_sw_r     <= mid_item.samp_width;
    a_tag_r    <= mid_item.tag;
    a_direct_r <= direct;
    a_neg_r    <= pattern[31];
    a_mag_r    <= pattern[31] ? (32'd0 - pattern) : pattern;
    b_kind_r   <= a_kind_r;
    b_status_r <= a_status_r;
    b_rate_r   <= a_rate_r;
    b_chan_r   <= a_chan_r;
    b_width_r  <= a_width_r;
    b_tag_r    <= a_tag_r;
    b_s_r      <= s;
    if (vb_r && b_kind_r == wpm_pkg::KIND_SAMPLE && b_tag_r == wpm_pkg::TAG_LEFT) begin
      held_r <= b_s_r;
    end
  end

endmodule

// ===== rtl/wav_pcm_stream_to_mono.sv =====
// Path: the byte that completes a result is registered in the work queue,
// then in two sample-unit stages (A, B), then in the output queue.
// Throughput: the parser takes one byte per cycle unless the work queue is
// full; the sample unit one work item per cycle as the output queue drains.
// Reset: synchronous, active low; both queues empty and the parser waits for
// the first header byte.
// ----------------------------------------------------------------------------
// wav_pcm_stream_to_mono
// WAV byte stream to mono samples: header parser, work queue, sample unit and
// output queue.
// ----------------------------------------------------------------------------
module wav_pcm_stream_to_mono #(
  parameter int MID_DEPTH = 4,
  parameter int OUT_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [7:0]         in_data_byte,
  input  logic               in_end_of_file,
  output logic               out_empty,
  input  logic               out_pop,
  output logic               out_result_kind,
  output logic [2:0]         out_status,
  output logic signed [16:0] out_mono_value,
  output logic [31:0]        out_sample_rate,
  output logic [1:0]         out_channel_total,
  output logic [2:0]         out_sample_width_bytes
);

  localparam int MID_W = $bits(wpm_pkg::mid_item_t);
  localparam int OUT_W = $bits(wpm_pkg::out_item_t);

  logic                             accept;
  logic                             mid_push, mid_pop, mid_empty;
  wpm_pkg::mid_item_t               mid_in, mid_head;
  logic [$clog2(MID_DEPTH+1)-1:0]   mid_count;
  logic                             out_wr, out_full;
  wpm_pkg::out_item_t               out_in, out_head;
  logic [$clog2(OUT_DEPTH+1)-1:0]   out_count;

  assign accept = in_push && !in_full;

  wpm_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .data_byte   (in_data_byte),
    .end_of_file (in_end_of_file),
    .item_push   (mid_push),
    .item        (mid_in)
  );

  wpm_fifo #(.WIDTH(MID_W), .DEPTH(MID_DEPTH)) u_mid_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (mid_push),
    .push_data (mid_in),
    .pop       (mid_pop),
    .pop_data  (mid_head),
    .empty     (mid_empty),
    .full      (in_full),
    .count     (mid_count)
  );

  wpm_back #(.OUT_DEPTH(OUT_DEPTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mid_empty (mid_empty),
    .mid_item  (mid_head),
    .mid_pop   (mid_pop),
    .out_count (out_count),
    .out_wr    (out_wr),
    .out_item  (out_in)
  );

  wpm_fifo #(.WIDTH(OUT_W), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (out_wr),
    .push_data (out_in),
    .pop       (out_pop),
    .pop_data  (out_head),
    .empty     (out_empty),
    .full      (out_full),
    .count     (out_count)
  );

  // Present the oldest result
  assign out_result_kind        = out_head.kind;
  assign out_status             = out_head.status;
  assign out_mono_value         = out_head.mono;
  assign out_sample_rate        = out_head.rate;
  assign out_channel_total      = out_head.chan;
  assign out_sample_width_bytes = out_head.width;

  a_out_room: assert property (@(posedge clk) disable iff (!rst_n)
    out_wr |-> !out_full)
    else $error("result written into a full output queue");

  a_mid_room: assert property (@(posedge clk) disable iff (!rst_n)
    mid_push |-> (accept && mid_count < ($clog2(MID_DEPTH+1))'(MID_DEPTH)))
    else $error("work item issued without room in the work queue");

  a_mid_pop: assert property (@(posedge clk) disable iff (!rst_n)
    mid_pop |-> !mid_empty)
    else $error("sample unit took from an empty work queue");

endmodule

// ===== sim/wpm_result_checker.sv =====
// ----------------------------------------------------------------------------
// wpm_result_checker
// Watches the byte and result channels of the WAV to mono converter, predicts
// every header report and mono sample from the accepted bytes, and compares
// each accepted result with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module wpm_result_checker
  import wpm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  logic               in_full,
  input  logic [7:0]         in_data_byte,
  input  logic               in_end_of_file,
  input  logic               out_empty,
  input  logic               out_pop,
  input  logic               out_result_kind,
  input  logic [2:0]         out_status,
  input  logic signed [16:0] out_mono_value,
  input  logic [31:0]        out_sample_rate,
  input  logic [1:0]         out_channel_total,
  input  logic [2:0]         out_sample_width_bytes,
  output int                 mismatches,
  output int                 owed
);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_DATA,
    PH_SKIP
  } parse_phase_t;

  // Header field offsets
  localparam int FMT_AT  = 20;
  localparam int CHAN_AT = 22;
  localparam int RATE_AT = 24;
  localparam int BITS_AT = 34;

  // Parser copy
  logic [5:0]   hdr_pos;
  parse_phase_t phase;
  logic         riff_good;
  logic [15:0]  fmt_word;
  logic [15:0]  chan_word;
  logic [31:0]  rate_word;
  logic [15:0]  bits_word;
  logic [23:0]  part_sample;
  logic [1:0]   bytes_held;
  int           held_left;
  logic         right_due;

  out_item_t owed_results[$];

  initial mismatches = 0;

  // Return the parser to the start of a new file
  function automatic void restart_parser();
    hdr_pos     = '0;
    phase       = PH_HEADER;
    riff_good   = 1'b1;
    fmt_word    = '0;
    chan_word   = '0;
    rate_word   = '0;
    bits_word   = '0;
    part_sample = '0;
    bytes_held  = '0;
    held_left   = 0;
    right_due   = 1'b0;
  endfunction

  // First failing check decides the status
  function automatic logic [2:0] header_verdict();
    if (!riff_good) return ST_NOT_WAVE;
    if (fmt_word != FORMAT_PCM) return ST_NOT_PCM;
    if (chan_word == 16'd0 || chan_word > 16'd2) return ST_BAD_CHANNELS;
    if (bits_word != 16'd8 && bits_word != 16'd16 && bits_word != 16'd24 &&
        bits_word != 16'd32) return ST_BAD_WIDTH;
    return ST_OK;
  endfunction

  // Bring one assembled sample to the 16-bit scale, truncating toward zero
  function automatic int scale_to_16(logic [31:0] raw, logic [2:0] width);
    int wide;
    case (width)
      SW_8BIT: begin
        wide = $signed(raw[7:0]) * 128;
      end
      SW_16BIT: begin
        wide = $signed(raw[15:0]);
      end
      SW_24BIT: begin
        wide = $signed({{8{raw[23]}}, raw[23:0]}) / 256;
      end
      default: begin
        wide = $signed(raw) / 65538;
      end
    endcase
    return wide;
  endfunction

  function automatic void push_sample(int value);
    out_item_t item;
    item      = '0;
    item.kind = KIND_SAMPLE;
    item.mono = 17'(value);
    owed_results.push_back(item);
  endfunction

  // Advance the parser copy by one accepted byte
  function automatic void absorb_byte(logic [7:0] b, logic eof);
    out_item_t   report;
    logic [2:0]  verdict;
    logic [2:0]  width;
    logic [31:0] raw;
    int          sample;
    case (phase)
      PH_HEADER: begin
        if (hdr_pos < 4 && b != RIFF_TAG[8*hdr_pos +: 8]) riff_good = 1'b0;
        if (hdr_pos == FMT_AT || hdr_pos == FMT_AT + 1)
          fmt_word[8*(hdr_pos - FMT_AT) +: 8] = b;
        if (hdr_pos == CHAN_AT || hdr_pos == CHAN_AT + 1)
          chan_word[8*(hdr_pos - CHAN_AT) +: 8] = b;
        if (hdr_pos >= RATE_AT && hdr_pos <= RATE_AT + 3)
          rate_word[8*(hdr_pos - RATE_AT) +: 8] = b;
        if (hdr_pos == BITS_AT || hdr_pos == BITS_AT + 1)
          bits_word[8*(hdr_pos - BITS_AT) +: 8] = b;
        if (hdr_pos + 1 >= HEADER_BYTES || eof) begin
          verdict     = (hdr_pos + 1 >= HEADER_BYTES) ? header_verdict() : ST_NOT_WAVE;
          report        = '0;
          report.kind   = KIND_REPORT;
          report.status = verdict;
          report.rate   = rate_word;
          if (verdict == ST_OK) begin
            report.chan  = chan_word[1:0];
            report.width = 3'(bits_word / 8);
          end
          owed_results.push_back(report);
          phase = (verdict == ST_OK) ? PH_DATA : PH_SKIP;
        end else begin
          hdr_pos = hdr_pos + 1'b1;
        end
      end
      PH_DATA: begin
        width = 3'(bits_word / 8);
        raw   = {8'h00, part_sample} | (32'(b) << (8*bytes_held));
        if (bytes_held + 1 >= width) begin
          sample      = scale_to_16(raw, width);
          part_sample = '0;
          bytes_held  = '0;
          if (chan_word == 16'd1) begin
            push_sample(2 * sample);
          end else if (!right_due) begin
            held_left = sample;
            right_due = 1'b1;
          end else begin
            push_sample(held_left + sample);
            right_due = 1'b0;
          end
        end else begin
          part_sample = raw[23:0];
          bytes_held  = bytes_held + 1'b1;
        end
      end
      default: begin
        // drop everything up to the end of the file
      end
    endcase
    if (eof) restart_parser();
  endfunction

  function automatic void compare_field(string field, longint want, longint got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    end
  endfunction

  // Match one accepted result against the oldest prediction
  function automatic void check_result();
    out_item_t want;
    if (owed_results.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected result, expected none, got kind %0d status %0d mono %0d",
               $time, out_result_kind, out_status, out_mono_value);
      return;
    end
    want = owed_results.pop_front();
    compare_field("result_kind", want.kind, out_result_kind);
    compare_field("status", want.status, out_status);
    compare_field("mono_value", $signed(want.mono), out_mono_value);
    compare_field("sample_rate", want.rate, out_sample_rate);
    compare_field("channel_total", want.chan, out_channel_total);
    compare_field("sample_width_bytes", want.width, out_sample_width_bytes);
  endfunction

  // Sample both channels on the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      restart_parser();
      owed_results.delete();
    end else begin
      if (in_push && !in_full) absorb_byte(in_data_byte, in_end_of_file);
      if (out_pop && !out_empty) check_result();
    end
    owed = owed_results.size();
  end

endmodule

// ===== sim/wav_pcm_stream_to_mono_tb.sv =====
// ----------------------------------------------------------------------------
// wav_pcm_stream_to_mono_tb
// Feeds WAV files byte by byte into the converter: a few short files first,
// then random files with good and broken headers of every sample width and
// channel count, random data and truncated frames. Both channels stall at
// random; the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module wav_pcm_stream_to_mono_tb;
  import wpm_pkg::*;

  localparam int ITEM_TARGET  = 1550;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 20;

  logic               clk;
  logic               rst_n;
  logic               in_push;
  logic               in_full;
  logic [7:0]         in_data_byte;
  logic               in_end_of_file;
  logic               out_empty;
  logic               out_pop;
  logic               out_result_kind;
  logic [2:0]         out_status;
  logic signed [16:0] out_mono_value;
  logic [31:0]        out_sample_rate;
  logic [1:0]         out_channel_total;
  logic [2:0]         out_sample_width_bytes;

  int         mismatches;
  int         results_owed;
  int         bytes_sent;
  int         cycle_count;
  logic       took_byte;
  int         pop_hold;
  int         pop_calm;
  logic [7:0] wav_bytes[$];

  wav_pcm_stream_to_mono dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_push                (in_push),
    .in_full                (in_full),
    .in_data_byte           (in_data_byte),
    .in_end_of_file         (in_end_of_file),
    .out_empty              (out_empty),
    .out_pop                (out_pop),
    .out_result_kind        (out_result_kind),
    .out_status             (out_status),
    .out_mono_value         (out_mono_value),
    .out_sample_rate        (out_sample_rate),
    .out_channel_total      (out_channel_total),
    .out_sample_width_bytes (out_sample_width_bytes)
  );

  wpm_result_checker u_checker (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_push                (in_push),
    .in_full                (in_full),
    .in_data_byte           (in_data_byte),
    .in_end_of_file         (in_end_of_file),
    .out_empty              (out_empty),
    .out_pop                (out_pop),
    .out_result_kind        (out_result_kind),
    .out_status             (out_status),
    .out_mono_value         (out_mono_value),
    .out_sample_rate        (out_sample_rate),
    .out_channel_total      (out_channel_total),
    .out_sample_width_bytes (out_sample_width_bytes),
    .mismatches             (mismatches),
    .owed                   (results_owed)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Note whether the byte on the ports was taken at this edge
  always @(posedge clk) begin
    took_byte <= in_push && !in_full;
  end

  // Abort a hung run
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result side: stall at random, with calm stretches of steady popping
  always @(negedge clk) begin
    if (!rst_n) begin
      out_pop  <= 1'b0;
      pop_hold = 0;
      pop_calm = 0;
    end else if (pop_hold > 0) begin
      out_pop <= 1'b0;
      pop_hold--;
    end else begin
      out_pop <= 1'b1;
      if (pop_calm > 0) begin
        pop_calm--;
      end else begin
        case ($urandom_range(0, 99)) inside
          [0:14]:  pop_hold = $urandom_range(1, 3);
          [15:17]: pop_hold = $urandom_range(8, 60);
          [18:19]: pop_calm = $urandom_range(50, 300);
          default: ;
        endcase
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Favour the extremes of a data byte
  function automatic logic [7:0] pick_data_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'h7F;
      2:       return 8'h80;
      3:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Offer one byte and hold it until it is taken; returns at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic eof, input int gap);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_push        <= 1'b1;
    in_data_byte   <= b;
    in_end_of_file <= eof;
    @(negedge clk);
    while (!took_byte) @(negedge clk);
    bytes_sent++;
  endtask

  task automatic play_file();
    bit calm;
    calm = ($urandom_range(0, 99) < 30);
    foreach (wav_bytes[i])
      send_byte(wav_bytes[i], i == wav_bytes.size() - 1, calm ? 0 : pick_gap());
  endtask

  // Hold the sender until every outstanding result has been popped
  task automatic hold_until_drained();
    in_push <= 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Build a random file: mostly well-formed headers with occasional faults
  task automatic build_random_file();
    logic [7:0]  hdr [HEADER_BYTES];
    logic [15:0] fmt;
    logic [15:0] chans;
    logic [15:0] bits;
    logic [31:0] rate;
    int          cut;
    int          data_len;
    int          r;
    wav_bytes.delete();
    // noise: random bytes that rarely pass the RIFF check
    if ($urandom_range(0, 99) < 8) begin
      repeat ($urandom_range(1, 60)) wav_bytes.push_back(8'($urandom));
      return;
    end
    foreach (hdr[i]) hdr[i] = 8'($urandom);
    for (int i = 0; i < 4; i++) hdr[i] = RIFF_TAG[8*i +: 8];
    if ($urandom_range(0, 99) < 10)
      hdr[$urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));

    fmt = FORMAT_PCM;
    if ($urandom_range(0, 99) < 10) begin
      case ($urandom_range(0, 2))
        0:       fmt = 16'h0000;
        1:       fmt = 16'h0101;
        default: fmt = 16'($urandom);
      endcase
      if (fmt == FORMAT_PCM) fmt = 16'h0003;
    end

    chans = 16'($urandom_range(1, 2));
    if ($urandom_range(0, 99) < 12) begin
      case ($urandom_range(0, 2))
        0:       chans = 16'd0;
        1:       chans = 16'd3;
        default: chans = 16'($urandom_range(3, 65535));
      endcase
    end

    bits = 16'(8 * $urandom_range(1, 4));
    if ($urandom_range(0, 99) < 12) begin
      case ($urandom_range(0, 2))
        0:       bits = 16'd0;
        1:       bits = 16'd12;
        default: bits = 16'($urandom);
      endcase
      if (bits == 16'd8 || bits == 16'd16 || bits == 16'd24 || bits == 16'd32)
        bits = 16'd40;
    end

    r = $urandom_range(0, 99);
    rate = (r < 15) ? 32'hFFFF_FFFF : (r < 25) ? 32'h0 : 32'($urandom);

    {hdr[21], hdr[20]} = fmt;
    {hdr[23], hdr[22]} = chans;
    {hdr[27], hdr[26], hdr[25], hdr[24]} = rate;
    {hdr[35], hdr[34]} = bits;

    // end of file inside the header, on its last byte, or after some data
    r = $urandom_range(0, 99);
    cut = (r < 10) ? $urandom_range(1, HEADER_BYTES - 1) : HEADER_BYTES;
    for (int i = 0; i < cut; i++) wav_bytes.push_back(hdr[i]);
    if (r >= 16 && cut == HEADER_BYTES) begin
      data_len = $urandom_range(1, 64);
      repeat (data_len) wav_bytes.push_back(pick_data_byte());
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_push        = 1'b0;
    in_data_byte   = 8'h00;
    in_end_of_file = 1'b0;
    out_pop        = 1'b0;
    bytes_sent     = 0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Single-byte file: report as too short with a zero rate
    wav_bytes = '{RIFF_TAG[7:0]};
    play_file();

    // File cut off inside the rate field: rate keeps the bytes seen so far
    wav_bytes.delete();
    for (int i = 0; i < 4; i++) wav_bytes.push_back(RIFF_TAG[8*i +: 8]);
    for (int i = 4; i < 20; i++) wav_bytes.push_back(8'($urandom));
    wav_bytes.push_back(FORMAT_PCM[7:0]);
    wav_bytes.push_back(FORMAT_PCM[15:8]);
    wav_bytes.push_back(8'd2);
    wav_bytes.push_back(8'd0);
    wav_bytes.push_back(8'hFF);
    wav_bytes.push_back(8'h80);
    play_file();
    hold_until_drained();

    // Random files, draining completely now and then
    for (int files = 1; bytes_sent < ITEM_TARGET; files++) begin
      build_random_file();
      play_file();
      if (files % 9 == 0) hold_until_drained();
    end

    in_push <= 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== wav_pcm_stream_to_mono.f =====
rtl/wpm_pkg.sv
rtl/wpm_fifo.sv
rtl/wpm_front.sv
rtl/wpm_back.sv
rtl/wav_pcm_stream_to_mono.sv
sim/wpm_result_checker.sv
sim/wav_pcm_stream_to_mono_tb.sv
